[rtl/core/lcr_pkg.sv]
// Package with shared types and constants of the LIP cache replacement block.
package lcr_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int NUM_WAYS_DEF = 16;

  localparam int STAMP_W     = 64;
  localparam int OP_W        = 2;
  localparam int SET_IN_W    = 6;
  localparam int WAY_IN_W    = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int VICTIM_W    = 4;
  localparam int WAY_CMP_W   = 6;

  localparam logic [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_VICTIM = 2'd0,
    OP_FILL   = 2'd1,
    OP_HIT    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic scan_en;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
    op_e  in_op;
    op_e  op;
  } sts_t;

endpackage

[rtl/core/lcr_ctrl.sv]
// Controller state machine that sequences clearing, set scans and updates.
module lcr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  lcr_pkg::sts_t sts_i,
  output lcr_pkg::cmd_t cmd_o
);
  import lcr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          unique case (sts_i.in_op)
            OP_VICTIM: state_d = ST_SCAN;
            OP_FILL:   state_d = ST_SCAN;
            OP_HIT:    state_d = ST_FINISH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        unique case (sts_i.op)
          OP_VICTIM: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          OP_FILL, OP_HIT: begin
            cmd_o.update = 1'b1;
            state_d      = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/lcr_datapath.sv]
// Datapath with the stamp memory, the minimum search, the hit counter and the output register.
module lcr_datapath #(
  parameter int NUM_SETS = lcr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = lcr_pkg::NUM_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lcr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [lcr_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  lcr_pkg::cmd_t                   cmd_i,
  output lcr_pkg::sts_t                   sts_o
);
  import lcr_pkg::*;

  localparam int DEPTH  = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SET_LUT_N = 2 ** SET_IN_W;

  logic [SET_IN_W-1:0] in_set;
  logic [WAY_IN_W-1:0] in_way;
  logic                in_hit;
  logic                in_wr;
  logic [SET_W-1:0]    set_lut [SET_LUT_N];

  logic [SET_W-1:0]   set_q;
  logic [WAY_W-1:0]   way_q;
  logic               way_ok_q;
  logic               hit_ok_q;
  op_e                op_q;

  logic [STAMP_W-1:0] mem_q [DEPTH];
  logic [STAMP_W-1:0] rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [STAMP_W-1:0] mem_wd;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  rd_addr;

  logic [ADDR_W-1:0]  clr_cnt_q;
  logic [WAY_W-1:0]   scan_cnt_q;
  logic               cmp_vld_q;
  logic [WAY_W-1:0]   cmp_way_q;
  logic [STAMP_W-1:0] min_q;
  logic [WAY_W-1:0]   best_q;
  logic               take;
  logic [STAMP_W-1:0] fill_stamp;
  logic               do_fill;
  logic               do_hit;

  logic [STAMP_W-1:0]  hit_cnt_q;
  logic                out_vld_q;
  logic [VICTIM_W-1:0] out_way_q;

  assign in_set = s_axis_tdata_i[SET_IN_W-1:0];
  assign in_way = s_axis_tdata_i[SET_IN_W +: WAY_IN_W];
  assign in_hit = s_axis_tdata_i[SET_IN_W + WAY_IN_W];
  assign in_wr  = s_axis_tdata_i[SET_IN_W + WAY_IN_W + 1];

  for (genvar g = 0; g < SET_LUT_N; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % NUM_SETS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q    <= set_lut[in_set];
      way_q    <= WAY_W'(in_way);
      way_ok_q <= WAY_CMP_W'(in_way) < WAY_CMP_W'(NUM_WAYS);
      hit_ok_q <= in_hit && !in_wr;
      op_q     <= op_e'(s_axis_tuser_i);
    end
  end

  assign base    = ADDR_W'(set_q) * ADDR_W'(NUM_WAYS);
  assign rd_addr = base + ADDR_W'(scan_cnt_q);

  assign fill_stamp = (min_q == STAMP_MIN) ? min_q : min_q - 1'b1;
  assign do_fill    = cmd_i.update && way_ok_q && (op_q == OP_FILL);
  assign do_hit     = cmd_i.update && way_ok_q && hit_ok_q && (op_q == OP_HIT);

  always_comb begin
    mem_we = cmd_i.clr_en || do_fill || do_hit;
    mem_wa = base + ADDR_W'(way_q);
    mem_wd = hit_cnt_q;
    if (cmd_i.clr_en) begin
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (do_fill) begin
      mem_wd = fill_stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.scan_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      scan_cnt_q <= '0;
      cmp_vld_q  <= 1'b0;
      hit_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_en) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      cmp_vld_q <= cmd_i.scan_en;
      if (do_hit) begin
        hit_cnt_q <= hit_cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign take = (cmp_way_q == '0) || ($signed(rd_q) < $signed(min_q));

  always_ff @(posedge clk_i) begin
    cmp_way_q <= scan_cnt_q;
    if (cmp_vld_q && take) begin
      min_q  <= rd_q;
      best_q <= cmp_way_q;
    end
    if (cmd_i.out_load) begin
      out_way_q <= VICTIM_W'(best_q);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_way_q);

  assign sts_o.clr_last  = clr_cnt_q == ADDR_W'(DEPTH - 1);
  assign sts_o.scan_last = scan_cnt_q == WAY_W'(NUM_WAYS - 1);
  assign sts_o.out_free  = !out_vld_q || m_axis_tready_i;
  assign sts_o.in_op     = op_e'(s_axis_tuser_i);
  assign sts_o.op        = op_q;

endmodule

[rtl/core/lip_cache_replacement.sv]
// Top level of the LIP cache replacement block.
// Victim and fill words scan the stamps of their set, one a cycle, then drain and finish;
// hit words go straight to finish, unknown ones are dropped; one word is worked on at a time.
// A victim word waits in the finish state only while the output is full and tready is low.
// After reset a clearing pass writes zero to all NUM_SETS * NUM_WAYS stamps, one per cycle,
// before the first input word is accepted; the hit counter resets to zero.
module lip_cache_replacement #(
  parameter int NUM_SETS = lcr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = lcr_pkg::NUM_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: set_index[5:0], way_index[9:6], hit_flag[10], is_write[11], zeros.
  input  logic [lcr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: operation[1:0].
  input  logic [lcr_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: victim_way[3:0], zeros.
  output logic [lcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import lcr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lcr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  lcr_datapath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

[sim/lip_victim_checker.sv]
// Checker for the LIP cache replacement block: predicts victim ways and compares output words.
module lip_victim_checker #(
  parameter int NUM_SETS = lcr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = lcr_pkg::NUM_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // Fields from bit 0: set_index[5:0], way_index[9:6], hit_flag[10], is_write[11], zeros.
  input  logic [lcr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: operation[1:0].
  input  logic [lcr_pkg::OP_W-1:0]        s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: victim_way[3:0], zeros.
  input  logic [lcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                              mismatches_o,
  output int                              pending_o,
  output int                              victims_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcr_pkg::*;

  logic signed [STAMP_W-1:0] stamps_q [NUM_SETS][NUM_WAYS];
  logic [STAMP_W-1:0]        hit_count_q;
  logic [VICTIM_W-1:0]       expected_victims_q [$];
  int                        fail_count;
  int                        checked_count;

  function automatic int oldest_way(input int set);
    int best;
    best = 0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (stamps_q[set][w] < stamps_q[set][best]) best = w;
    end
    return best;
  endfunction

  initial begin
    mismatches_o      = 0;
    pending_o         = 0;
    victims_checked_o = 0;
    fail_count        = 0;
    checked_count     = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int                        set;
    int                        way;
    logic                      hit;
    logic                      wr;
    logic [VICTIM_W-1:0]       want;
    logic signed [STAMP_W-1:0] floor_stamp;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < NUM_WAYS; w++) stamps_q[s][w] = '0;
      end
      hit_count_q = '0;
      expected_victims_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_victims_q.size() == 0) begin
          fail_count++;
          $error("victim_way: unexpected word, expected none, actual %0d",
                 m_axis_tdata_i[VICTIM_W-1:0]);
        end else begin
          want = expected_victims_q.pop_front();
          checked_count++;
          if (m_axis_tdata_i[VICTIM_W-1:0] !== want) begin
            fail_count++;
            $error("victim_way mismatch: expected %0d, actual %0d",
                   want, m_axis_tdata_i[VICTIM_W-1:0]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        set = int'(s_axis_tdata_i[5:0]) % NUM_SETS;
        way = int'(s_axis_tdata_i[9:6]);
        hit = s_axis_tdata_i[10];
        wr  = s_axis_tdata_i[11];
        case (s_axis_tuser_i)
          OP_VICTIM: expected_victims_q.push_back(VICTIM_W'(oldest_way(set)));
          OP_FILL: begin
            if (way < NUM_WAYS) begin
              floor_stamp = stamps_q[set][oldest_way(set)];
              stamps_q[set][way] = (floor_stamp == STAMP_MIN) ? floor_stamp
                                                              : floor_stamp - 1;
            end
          end
          OP_HIT: begin
            if (way < NUM_WAYS && hit && !wr) begin
              stamps_q[set][way] = hit_count_q;
              hit_count_q        = hit_count_q + 1;
            end
          end
          default: ;
        endcase
      end
    end
    mismatches_o      <= fail_count;
    pending_o         <= expected_victims_q.size();
    victims_checked_o <= checked_count;
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the LIP cache replacement block: stimulus, stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcr_pkg::*;

  localparam int NUM_SETS     = NUM_SETS_DEF;
  localparam int NUM_WAYS     = NUM_WAYS_DEF;
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int IDLE_PCT     = 28;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   quiet = 1'b0;
  int                     cycle_count = 0;
  int                     words_sent = 0;
  int                     mismatches;
  int                     pending;
  int                     victims_checked;

  always #5 clk_i = ~clk_i;

  lip_cache_replacement #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata)
  );

  lip_victim_checker #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_tdata),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .victims_checked_o(victims_checked)
  );

  always @(posedge clk_i) begin
    m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [5:0] set,
                           input logic [3:0] way, input logic hit, input logic wr);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0000, wr, hit, way, set};
    do @(posedge clk_i); while (!s_ready);
    words_sent++;
  endtask

  initial begin : stimulus
    logic [5:0] set;
    logic [3:0] way;
    int         pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh sets tie everywhere, so the lowest way wins.
    send_word(OP_VICTIM, 6'd0, 4'd0, 1'b0, 1'b0);
    send_word(OP_VICTIM, 6'd63, 4'd15, 1'b1, 1'b1);
    send_word(OP_FILL, 6'd0, 4'd15, 1'b0, 1'b0);
    send_word(OP_VICTIM, 6'd0, 4'd0, 1'b0, 1'b0);
    send_word(OP_FILL, 6'd0, 4'd0, 1'b1, 1'b1);
    send_word(OP_VICTIM, 6'd0, 4'd7, 1'b0, 1'b0);
    send_word(OP_HIT, 6'd0, 4'd0, 1'b1, 1'b0);
    send_word(OP_VICTIM, 6'd0, 4'd0, 1'b0, 1'b0);
    // A miss and a write hit must leave the stamps alone.
    send_word(OP_HIT, 6'd0, 4'd15, 1'b0, 1'b0);
    send_word(OP_HIT, 6'd0, 4'd15, 1'b1, 1'b1);
    send_word(OP_VICTIM, 6'd0, 4'd0, 1'b0, 1'b0);
    send_word(OP_UNKNOWN, 6'd63, 4'd15, 1'b1, 1'b1);
    send_word(OP_UNKNOWN, 6'd0, 4'd0, 1'b0, 1'b0);
    send_word(OP_HIT, 6'd63, 4'd0, 1'b1, 1'b0);
    send_word(OP_FILL, 6'd63, 4'd15, 1'b0, 1'b0);
    send_word(OP_FILL, 6'd63, 4'd8, 1'b0, 1'b0);
    send_word(OP_VICTIM, 6'd63, 4'd0, 1'b0, 1'b0);
    send_word(OP_HIT, 6'd63, 4'd8, 1'b1, 1'b0);
    send_word(OP_HIT, 6'd63, 4'd15, 1'b1, 1'b0);
    send_word(OP_VICTIM, 6'd63, 4'd0, 1'b0, 1'b0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet <= (i >= 700 && i < 1000);
      if ($urandom_range(0, 3) != 0) set = 6'($urandom_range(0, 7) * 9);
      else set = 6'($urandom_range(0, 63));
      way  = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_word(OP_VICTIM, set, way, 1'($urandom), 1'($urandom));
      end else if (pick < 55) begin
        send_word(OP_FILL, set, way, 1'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        send_word(OP_HIT, set, way, $urandom_range(0, 9) != 0, $urandom_range(0, 5) == 0);
      end else begin
        send_word(OP_UNKNOWN, set, way, 1'($urandom), 1'($urandom));
      end
    end
    s_valid <= 1'b0;
    quiet   <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (NUM_WAYS + 8) @(posedge clk_i);
    $display("Sent %0d words over all operations, hot and spread sets, every way.", words_sent);
    $display("Checked %0d victim words under random stalls on both sides.", victims_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lcr_pkg.sv
rtl/core/lcr_ctrl.sv
rtl/core/lcr_datapath.sv
rtl/core/lip_cache_replacement.sv
sim/lip_victim_checker.sv
sim/tb_top.sv
